[rtl/sebr_pkg.sv]
// Shared types, constants and register codes of the Sobel edge blend unit.
`default_nettype none
package sebr_pkg;

  localparam int unsigned MAX_LINE_WIDTH_DEF = 2048;
  localparam int unsigned COL_W_DEF          = 11;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [11:0] FRAME_WIDTH_RST     = 12'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST    = 16'd480;
  localparam logic [8:0]  BLEND_INTENSITY_RST = 9'd256;
  localparam logic [8:0]  INTEN_MAX           = 9'd256;

  localparam int unsigned GRAD_W = 12;
  localparam int unsigned SQ_W   = 21;
  localparam int unsigned ROOT_W = 30;
  localparam int unsigned MAG_W  = 15;
  localparam int unsigned ESUM_W = 17;
  localparam int unsigned EDGE_W = 12;
  localparam logic [EDGE_W-1:0] EDGE_MAX = 12'd4080;
  localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = 30'h1000_0000;

  localparam int KERN_X [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  localparam int KERN_Y [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT    = 2'd1,
    CFG_BLEND_INTENSITY = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WIN,
    ST_WAIT,
    ST_SUM,
    ST_MIX,
    ST_EMIT_I,
    ST_EMIT_B
  } sebr_state_e;

  typedef struct packed {
    logic sum_en;
    logic mix_en;
  } merge_ctl_t;

endpackage
`default_nettype wire

[rtl/sebr_if.sv]
// Channel interfaces: pixel input, result output and configuration write.
`default_nettype none
interface sebr_pix_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  modport source (output valid, frame_start, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink   (input valid, frame_start, red_in, green_in, blue_in, alpha_in,
                  output ready);
endinterface

interface sebr_pix_out_if #(parameter int unsigned COL_W = sebr_pkg::COL_W_DEF);
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_col;
  logic [15:0]      out_row;
  logic [7:0]       red_out;
  logic [7:0]       green_out;
  logic [7:0]       blue_out;
  logic [7:0]       alpha_out;
  logic             is_border;
  logic             last_of_run;
  modport source (output valid, out_col, out_row, red_out, green_out, blue_out,
                  alpha_out, is_border, last_of_run, input ready);
  modport sink   (input valid, out_col, out_row, red_out, green_out, blue_out,
                  alpha_out, is_border, last_of_run, output ready);
endinterface

interface sebr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sebr_pkg::CFG_IDX_W-1:0]  index;
  logic [sebr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/sebr_lane.sv]
// One colour lane: Sobel gradients, squared magnitude and iterative root.
`default_nettype none
module sebr_lane (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [7:0]                 pix_i [9],
  output logic [sebr_pkg::MAG_W-1:0]      mag_o,
  output logic                            done_o
);

  logic signed [sebr_pkg::GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;
  logic [sebr_pkg::SQ_W-1:0]          sq;
  logic [sebr_pkg::ROOT_W-1:0]        v_q, res_q, bit_q, trial;
  logic                               sq_pend_q, busy_q, done_q;

  always_comb begin
    gx_d = '0;
    gy_d = '0;
    for (int i = 0; i < 9; i++) begin
      gx_d = gx_d + sebr_pkg::GRAD_W'(sebr_pkg::KERN_X[i] * $signed({4'b0, pix_i[i]}));
      gy_d = gy_d + sebr_pkg::GRAD_W'(sebr_pkg::KERN_Y[i] * $signed({4'b0, pix_i[i]}));
    end
  end

  assign sq    = sebr_pkg::SQ_W'(gx_q * gx_q) + sebr_pkg::SQ_W'(gy_q * gy_q);
  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_pend_q <= 1'b0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
    end else if (start_i) begin
      sq_pend_q <= 1'b1;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
    end else if (sq_pend_q) begin
      sq_pend_q <= 1'b0;
      busy_q    <= 1'b1;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end else if (sq_pend_q) begin
      v_q   <= {1'b0, sq, 8'b0};
      res_q <= '0;
      bit_q <= sebr_pkg::ROOT_BIT_INIT;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign mag_o  = res_q[sebr_pkg::MAG_W-1:0];
  assign done_o = done_q;

endmodule
`default_nettype wire

[rtl/sebr_merge.sv]
// Merge stage: sum and clamp lane magnitudes, then blend with the centre pixel.
`default_nettype none
module sebr_merge (
  input  wire logic                       clk_i,
  input  wire sebr_pkg::merge_ctl_t       ctl_i,
  input  wire logic [sebr_pkg::MAG_W-1:0] mag_i [3],
  input  wire logic [7:0]                 orig_i [3],
  input  wire logic [8:0]                 inten_i,
  output logic [7:0]                      rgb_o [3]
);

  logic [sebr_pkg::ESUM_W-1:0] esum;
  logic [sebr_pkg::EDGE_W-1:0] edge_q;
  logic [8:0]                  inten;
  logic [21:0]                 mix [3];
  logic [7:0]                  rgb_q [3];

  assign esum  = sebr_pkg::ESUM_W'(mag_i[0]) + sebr_pkg::ESUM_W'(mag_i[1])
               + sebr_pkg::ESUM_W'(mag_i[2]);
  assign inten = (inten_i > sebr_pkg::INTEN_MAX) ? sebr_pkg::INTEN_MAX : inten_i;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mix[ch] = 22'({orig_i[ch], 4'b0} * (sebr_pkg::INTEN_MAX - inten))
              + 22'(edge_q * inten);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      edge_q <= (esum > sebr_pkg::ESUM_W'(sebr_pkg::EDGE_MAX)) ? sebr_pkg::EDGE_MAX
                                                               : esum[sebr_pkg::EDGE_W-1:0];
    end
    if (ctl_i.mix_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        rgb_q[ch] <= (mix[ch][21:12] > 10'd255) ? 8'd255 : mix[ch][19:12];
      end
    end
  end

  assign rgb_o = rgb_q;

endmodule
`default_nettype wire

[rtl/sobel_edge_blend_rgb_unit.sv]
// Top level of the Sobel edge blend unit: line stores, window, lanes and control.
//
// channel     modport  moves
// pix_in_i    sink     one RGBA pixel with frame_start per transaction
// pix_out_o   source   one result pixel with coordinates per transaction
// cfg_i       sink     one register write (index, data) per transaction
//
// Border-only pixels go through LOAD and EMIT_B; no-result ones through LOAD alone.
// Interior pixels add WIN, WAIT (15-step square root per lane), SUM, MIX and EMIT_I.
// One pixel is in flight at a time; pix_in_i.ready is high only when idle.
// Reset clears window and coordinates, presets config; line stores need no clearing.
// A stalled output holds the result and the following input.
`default_nettype none
module sobel_edge_blend_rgb_unit #(
  parameter int unsigned MAX_LINE_WIDTH = sebr_pkg::MAX_LINE_WIDTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  sebr_pix_in_if.sink    pix_in_i,
  sebr_pix_out_if.source pix_out_o,
  sebr_cfg_if.sink       cfg_i
);

  localparam int unsigned CW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned WW = (CW + 1 > 12) ? CW + 1 : 12;
  localparam logic [WW-1:0] MAXW = WW'(MAX_LINE_WIDTH);

  sebr_pkg::sebr_state_e state_q, state_d;

  logic [11:0] fw_q;
  logic [15:0] fh_q;
  logic [8:0]  bi_q;
  logic [CW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;

  logic [WW-1:0] fw_ext, w_eff, c_raw, c1;
  logic [15:0]   h_eff;
  logic [16:0]   r_raw, r_nx;
  logic [CW-1:0] c_cur;
  logic [15:0]   r_cur;
  logic          interior, border, in_acc, out_acc, cfg_acc;

  logic [CW-1:0] c_q;
  logic [15:0]   r_q;
  logic [31:0]   px_q, rd_old_q, rd_new_q;
  logic          int_q, brd_q;
  logic [31:0]   old_mem [MAX_LINE_WIDTH];
  logic [31:0]   new_mem [MAX_LINE_WIDTH];
  logic [31:0]   win_q [9];

  logic                       lane_start;
  logic [7:0]                 lane_pix [3][9];
  logic [sebr_pkg::MAG_W-1:0] mag [3];
  logic [2:0]                 lane_done;
  logic [7:0]                 orig [3];
  logic [7:0]                 rgb [3];
  sebr_pkg::merge_ctl_t       mctl;

  assign in_acc  = pix_in_i.valid && pix_in_i.ready;
  assign out_acc = pix_out_o.valid && pix_out_o.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= sebr_pkg::FRAME_WIDTH_RST;
      fh_q <= sebr_pkg::FRAME_HEIGHT_RST;
      bi_q <= sebr_pkg::BLEND_INTENSITY_RST;
    end else if (cfg_acc) begin
      unique case (sebr_pkg::cfg_idx_e'(cfg_i.index))
        sebr_pkg::CFG_FRAME_WIDTH:     fw_q <= cfg_i.data[11:0];
        sebr_pkg::CFG_FRAME_HEIGHT:    fh_q <= cfg_i.data[15:0];
        sebr_pkg::CFG_BLEND_INTENSITY: bi_q <= cfg_i.data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = WW'(fw_q);
    if (fw_ext == '0) w_eff = WW'(1);
    else if (fw_ext > MAXW) w_eff = MAXW;
    else w_eff = fw_ext;
    h_eff = (fh_q == '0) ? 16'd1 : fh_q;

    c_raw = WW'(col_q);
    r_raw = {1'b0, row_q};
    if (pix_in_i.frame_start) begin
      c_raw = '0;
      r_raw = '0;
    end else if (c_raw >= w_eff) begin
      c_raw = '0;
      r_raw = r_raw + 17'd1;
    end
    if (r_raw >= {1'b0, h_eff}) r_raw = '0;
    c_cur = c_raw[CW-1:0];
    r_cur = r_raw[15:0];

    interior = (c_raw >= WW'(2)) && (r_cur >= 16'd2);
    border   = (c_raw == '0) || (r_cur == '0) || (c_raw == w_eff - WW'(1))
            || (r_cur == h_eff - 16'd1);

    c1   = c_raw + WW'(1);
    r_nx = {1'b0, r_cur};
    if (c1 >= w_eff) begin
      c1   = '0;
      r_nx = r_nx + 17'd1;
      if (r_nx >= {1'b0, h_eff}) r_nx = '0;
    end
    col_d = c1[CW-1:0];
    row_d = r_nx[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      int_q <= 1'b0;
      brd_q <= 1'b0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
      int_q <= interior;
      brd_q <= border;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      c_q      <= c_cur;
      r_q      <= r_cur;
      px_q     <= {pix_in_i.alpha_in, pix_in_i.blue_in, pix_in_i.green_in, pix_in_i.red_in};
      rd_old_q <= old_mem[c_cur];
      rd_new_q <= new_mem[c_cur];
    end
    if (state_q == sebr_pkg::ST_LOAD) begin
      old_mem[c_q] <= rd_new_q;
      new_mem[c_q] <= px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (state_q == sebr_pkg::ST_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= rd_old_q;
      win_q[5] <= rd_new_q;
      win_q[8] <= px_q;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) lane_pix[ch][i] = win_q[i][8*ch +: 8];
      orig[ch] = win_q[4][8*ch +: 8];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    sebr_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lane_start),
      .pix_i   (lane_pix[g]),
      .mag_o   (mag[g]),
      .done_o  (lane_done[g])
    );
  end

  sebr_merge u_merge (
    .clk_i   (clk_i),
    .ctl_i   (mctl),
    .mag_i   (mag),
    .orig_i  (orig),
    .inten_i (bi_q),
    .rgb_o   (rgb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sebr_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sebr_pkg::ST_IDLE: if (in_acc) state_d = sebr_pkg::ST_LOAD;
      sebr_pkg::ST_LOAD: begin
        if (int_q) state_d = sebr_pkg::ST_WIN;
        else if (brd_q) state_d = sebr_pkg::ST_EMIT_B;
        else state_d = sebr_pkg::ST_IDLE;
      end
      sebr_pkg::ST_WIN:  state_d = sebr_pkg::ST_WAIT;
      sebr_pkg::ST_WAIT: if (lane_done[0]) state_d = sebr_pkg::ST_SUM;
      sebr_pkg::ST_SUM:  state_d = sebr_pkg::ST_MIX;
      sebr_pkg::ST_MIX:  state_d = sebr_pkg::ST_EMIT_I;
      sebr_pkg::ST_EMIT_I: begin
        if (pix_out_o.ready) state_d = brd_q ? sebr_pkg::ST_EMIT_B : sebr_pkg::ST_IDLE;
      end
      sebr_pkg::ST_EMIT_B: if (pix_out_o.ready) state_d = sebr_pkg::ST_IDLE;
      default: state_d = sebr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pix_in_i.ready        = (state_q == sebr_pkg::ST_IDLE);
    lane_start            = (state_q == sebr_pkg::ST_WIN);
    mctl.sum_en           = (state_q == sebr_pkg::ST_SUM);
    mctl.mix_en           = (state_q == sebr_pkg::ST_MIX);
    pix_out_o.valid       = 1'b0;
    pix_out_o.out_col     = c_q;
    pix_out_o.out_row     = r_q;
    pix_out_o.red_out     = px_q[7:0];
    pix_out_o.green_out   = px_q[15:8];
    pix_out_o.blue_out    = px_q[23:16];
    pix_out_o.alpha_out   = px_q[31:24];
    pix_out_o.is_border   = 1'b1;
    pix_out_o.last_of_run = 1'b1;
    unique case (state_q)
      sebr_pkg::ST_EMIT_I: begin
        pix_out_o.valid       = 1'b1;
        pix_out_o.out_col     = c_q - CW'(1);
        pix_out_o.out_row     = r_q - 16'd1;
        pix_out_o.red_out     = rgb[0];
        pix_out_o.green_out   = rgb[1];
        pix_out_o.blue_out    = rgb[2];
        pix_out_o.alpha_out   = win_q[4][31:24];
        pix_out_o.is_border   = 1'b0;
        pix_out_o.last_of_run = !brd_q;
      end
      sebr_pkg::ST_EMIT_B: pix_out_o.valid = 1'b1;
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pix_in_i.ready && pix_out_o.valid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !pix_in_i.ready)
    else $error("ready held after an accepted transaction");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&lane_done) || !(|lane_done))
    else $error("colour lanes out of step");

  a_interior_border_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !pix_out_o.is_border && brd_q) |=> (pix_out_o.valid && pix_out_o.is_border))
    else $error("border result did not follow interior result");

endmodule
`default_nettype wire
